/* rtl/tsrb_pkg.sv */
`default_nettype none
package tsrb_pkg;

  localparam int unsigned CAPACITY_DEF  = 4096;
  localparam int unsigned SEG_BYTES_DEF = 8;
  localparam int unsigned READ_MAX_DEF  = 64;
  localparam int unsigned CAP_REG_W     = 13;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CAPACITY = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef enum logic {
    CFG_BASE_SEQ = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_e;

  // per-bank flags toward the merge stage
  typedef struct packed {
    logic present;
    logic conflict;
    logic fresh;
  } lane_stat_t;

  // merged view of all banks
  typedef struct packed {
    logic       conflict;
    logic [3:0] fresh;
    logic [3:0] lead;
  } merge_t;

endpackage
`default_nettype wire

/* rtl/tsrb_if.sv */
`default_nettype none
interface tsrb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seq;
  logic [3:0]  segment_length;
  logic [63:0] segment_bytes;
  logic [6:0]  read_limit;

  modport source (output valid, operation, seq, segment_length, segment_bytes, read_limit,
                  input ready);
  modport sink (input valid, operation, seq, segment_length, segment_bytes, read_limit,
                output ready);
endinterface

interface tsrb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] accepted_count;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [6:0] produced_count;
  logic       last;

  modport source (output valid, status, accepted_count, data_byte, byte_valid,
                  produced_count, last, input ready);
  modport sink (input valid, status, accepted_count, data_byte, byte_valid,
                produced_count, last, output ready);
endinterface
`default_nettype wire

/* rtl/tsrb_lane.sv */
`default_nettype none
module tsrb_lane #(
  parameter int unsigned ROWS = 512,
  parameter int unsigned RW   = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [RW-1:0]        rd_row_i,
  input  wire logic                 wr_en_i,
  input  wire logic [RW-1:0]        wr_row_i,
  input  wire logic [8:0]           wr_word_i,
  input  wire logic                 cmp_valid_i,
  input  wire logic [7:0]           cmp_byte_i,
  output logic [7:0]                rd_byte_o,
  output tsrb_pkg::lane_stat_t      stat_o
);
  import tsrb_pkg::*;

  // {present, data}
  logic [8:0] mem [ROWS];
  logic [8:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_row_i] <= wr_word_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rdata_q <= mem[rd_row_i];
  end

  always_comb begin
    rd_byte_o       = rdata_q[7:0];
    stat_o.present  = rdata_q[8];
    stat_o.conflict = cmp_valid_i && rdata_q[8] && (rdata_q[7:0] != cmp_byte_i);
    stat_o.fresh    = cmp_valid_i && !rdata_q[8];
  end

endmodule
`default_nettype wire

/* rtl/tsrb_merge.sv */
`default_nettype none
module tsrb_merge #(
  parameter int unsigned NB = 8,
  parameter int unsigned LB = 3,
  parameter int unsigned XW = 14
) (
  input  wire tsrb_pkg::lane_stat_t stat_i [NB],
  input  wire logic [XW-1:0]        base_i,
  input  wire logic [XW-1:0]        cap_i,
  output tsrb_pkg::merge_t          merge_o
);
  import tsrb_pkg::*;

  logic [LB-1:0] bank;
  logic          run;

  always_comb begin
    merge_o = '0;
    run     = 1'b1;
    bank    = '0;
    for (int k = 0; k < NB; k++) begin
      merge_o.conflict = merge_o.conflict | stat_i[k].conflict;
      merge_o.fresh    = merge_o.fresh + 4'(stat_i[k].fresh);
      // walk in byte order starting at the bank that holds base
      bank = base_i[LB-1:0] + LB'(k);
      run  = run && stat_i[bank].present && ((base_i + XW'(k)) < cap_i);
      merge_o.lead = merge_o.lead + 4'(run);
    end
  end

endmodule
`default_nettype wire

/* rtl/tcp_stream_reassembly_buffer_top.sv */
`default_nettype none
// TCP stream reassembly buffer.
// in_ch (valid/ready) takes one request: a push of up to SEG_BYTES bytes at a
// sequence number, or a read of the contiguous bytes at the read position.
// out_ch (valid/ready) returns the results; last marks the final one of a request.
// A push returns one result: a registered read of all byte banks, then compare
// and write in the same lanes; the block is back in idle, ready for the next
// request, once that result is in the output register.
// A read scans the present bits NB bytes per bank read until the run ends or
// passes the limit, then emits its bytes with one bank read per byte.
// One request is worked at a time; in_ch.ready is high only between requests.
// The output register holds a result while out_ch.ready is low and the block
// waits; the next request can still be taken while the last result is waiting.
// Reset and every write of the base sequence register start a clearing pass
// over ROWS rows (CAPACITY / NB rounded up, 512 at defaults) that zeroes the
// present map; no request is accepted meanwhile. Configuration writes must be
// made only while no request is in flight; the block does not enforce this.
module tcp_stream_reassembly_buffer_top #(
  parameter int unsigned CAPACITY  = tsrb_pkg::CAPACITY_DEF,
  parameter int unsigned SEG_BYTES = tsrb_pkg::SEG_BYTES_DEF,
  parameter int unsigned READ_MAX  = tsrb_pkg::READ_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tsrb_in_if.sink          in_ch,
  tsrb_out_if.source       out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import tsrb_pkg::*;

  localparam int unsigned LB0  = $clog2(SEG_BYTES);
  localparam int unsigned LB   = (LB0 > 0) ? LB0 : 1;
  localparam int unsigned NB   = 1 << LB;
  localparam int unsigned ROWS = (CAPACITY + NB - 1) / NB;
  localparam int unsigned RW0  = $clog2(ROWS);
  localparam int unsigned RW   = (RW0 > 0) ? RW0 : 1;
  localparam int unsigned AW   = $clog2(CAPACITY + 1);
  localparam int unsigned XW   = $clog2(CAPACITY + READ_MAX + 2 * NB + 1);
  localparam int unsigned VW   = $clog2(READ_MAX + NB + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PUSH_CHK, S_PUSH_CMP, S_SCAN_RD, S_SCAN_EV, S_EMIT_RD, S_EMIT_WAIT
  } state_e;

  state_e          state_q;
  logic [RW-1:0]   clr_q;
  logic [31:0]     init_q;
  logic [CAP_REG_W-1:0] capreg_q;
  logic [AW-1:0]   pos_q;
  logic [VW-1:0]   avail_q;
  logic [6:0]      e_q;

  logic [31:0]     seq_q;
  logic [3:0]      len_q;
  logic [63:0]     bytes_q;
  logic [6:0]      lim_q;

  logic            ov_q;
  logic [1:0]      st_q;
  logic [3:0]      acc_q;
  logic [7:0]      db_q;
  logic            bv_q;
  logic [6:0]      pc_q;
  logic            last_q;

  logic [31:0]     off;
  logic [XW-1:0]   cap;
  logic [XW-1:0]   base;
  logic            cap_err;
  logic            out_free;

  logic            rd_en;
  logic            wr_en;
  logic [RW-1:0]   rd_row  [NB];
  logic [RW-1:0]   wr_row  [NB];
  logic [8:0]      wr_word [NB];
  logic            wr_mask [NB];
  logic            cmp_valid [NB];
  logic [7:0]      cmp_byte  [NB];
  logic [7:0]      rd_byte   [NB];
  lane_stat_t      stat      [NB];
  merge_t          mrg;

  logic [LB-1:0]   k_b;
  logic [XW-1:0]   addr_b;
  logic [VW-1:0]   navail;
  logic            scan_done;
  logic [6:0]      e_next;
  logic            e_last;

  assign off      = seq_q - init_q;
  assign cap      = (32'(capreg_q) > 32'(CAPACITY)) ? XW'(CAPACITY) : XW'(capreg_q);
  assign cap_err  = ({1'b0, off} + 33'(len_q)) > 33'(cap);
  assign out_free = !ov_q || out_ch.ready;

  always_comb begin
    case (state_q)
      S_PUSH_CHK, S_PUSH_CMP: base = XW'(off);
      S_SCAN_RD, S_SCAN_EV:   base = XW'(pos_q) + XW'(avail_q);
      default:                base = XW'(pos_q) + XW'(e_q);
    endcase
  end

  // bank b holds segment byte k_b = b - base (mod NB)
  always_comb begin
    k_b    = '0;
    addr_b = '0;
    for (int b = 0; b < NB; b++) begin
      k_b          = LB'(b) - base[LB-1:0];
      addr_b       = base + XW'(k_b);
      rd_row[b]    = RW'(addr_b >> LB);
      cmp_valid[b] = (4'(k_b) < len_q);
      cmp_byte[b]  = bytes_q[8 * k_b +: 8];
      wr_row[b]    = (state_q == S_CLEAR) ? clr_q : rd_row[b];
      wr_word[b]   = (state_q == S_CLEAR) ? 9'd0 : {1'b1, cmp_byte[b]};
      wr_mask[b]   = (state_q == S_CLEAR) || cmp_valid[b];
    end
  end

  assign rd_en = ((state_q == S_PUSH_CHK) && !cap_err && (len_q != 4'd0)) ||
                 (state_q == S_SCAN_RD) || (state_q == S_EMIT_RD);
  assign wr_en = (state_q == S_CLEAR) ||
                 ((state_q == S_PUSH_CMP) && out_free && !mrg.conflict);

  for (genvar b = 0; b < NB; b++) begin : g_lane
    tsrb_lane #(.ROWS(ROWS), .RW(RW)) u_lane (
      .clk_i       (clk_i),
      .rd_en_i     (rd_en),
      .rd_row_i    (rd_row[b]),
      .wr_en_i     (wr_en && wr_mask[b]),
      .wr_row_i    (wr_row[b]),
      .wr_word_i   (wr_word[b]),
      .cmp_valid_i (cmp_valid[b]),
      .cmp_byte_i  (cmp_byte[b]),
      .rd_byte_o   (rd_byte[b]),
      .stat_o      (stat[b])
    );
  end

  tsrb_merge #(.NB(NB), .LB(LB), .XW(XW)) u_merge (
    .stat_i  (stat),
    .base_i  (base),
    .cap_i   (cap),
    .merge_o (mrg)
  );

  assign navail    = avail_q + VW'(mrg.lead);
  assign scan_done = (mrg.lead != 4'(NB)) || (navail > VW'(lim_q));
  assign e_next    = e_q + 7'd1;
  assign e_last    = (VW'(e_next) == avail_q);

  assign in_ch.ready           = (state_q == S_IDLE);
  assign out_ch.valid          = ov_q;
  assign out_ch.status         = st_q;
  assign out_ch.accepted_count = acc_q;
  assign out_ch.data_byte      = db_q;
  assign out_ch.byte_valid     = bv_q;
  assign out_ch.produced_count = pc_q;
  assign out_ch.last           = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      init_q   <= '0;
      capreg_q <= CAP_REG_W'(4096);
      pos_q    <= '0;
      avail_q  <= '0;
      e_q      <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (ov_q && out_ch.ready) ov_q <= 1'b0;

      if (cfg_we_i && (cfg_idx_i == CFG_BASE_SEQ)) begin
        init_q  <= cfg_data_i;
        pos_q   <= '0;
        clr_q   <= '0;
        state_q <= S_CLEAR;
      end else begin
        case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + RW'(1);
            if (clr_q == RW'(ROWS - 1)) state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (in_ch.valid) begin
              seq_q   <= in_ch.seq;
              len_q   <= (in_ch.segment_length > 4'(SEG_BYTES)) ? 4'(SEG_BYTES)
                                                                : in_ch.segment_length;
              bytes_q <= in_ch.segment_bytes;
              lim_q   <= (in_ch.read_limit > 7'(READ_MAX)) ? 7'(READ_MAX)
                                                           : in_ch.read_limit;
              avail_q <= '0;
              e_q     <= '0;
              state_q <= (in_ch.operation == OP_READ) ? S_SCAN_RD : S_PUSH_CHK;
            end
          end
          S_PUSH_CHK: begin
            if (len_q == 4'd0 || cap_err) begin
              if (out_free) begin
                ov_q    <= 1'b1;
                st_q    <= (len_q == 4'd0) ? ST_OK : ST_CAPACITY;
                acc_q   <= '0;
                db_q    <= '0;
                bv_q    <= 1'b0;
                pc_q    <= '0;
                last_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end else begin
              state_q <= S_PUSH_CMP;
            end
          end
          S_PUSH_CMP: begin
            if (out_free) begin
              ov_q    <= 1'b1;
              st_q    <= mrg.conflict ? ST_CONFLICT : ST_OK;
              acc_q   <= mrg.conflict ? 4'd0 : mrg.fresh;
              db_q    <= '0;
              bv_q    <= 1'b0;
              pc_q    <= '0;
              last_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
          S_SCAN_RD: state_q <= S_SCAN_EV;
          S_SCAN_EV: begin
            if (!scan_done) begin
              avail_q <= navail;
              state_q <= S_SCAN_RD;
            end else if (navail > VW'(lim_q) || navail == '0) begin
              if (out_free) begin
                ov_q    <= 1'b1;
                st_q    <= (navail == '0) ? ST_OK : ST_TRUNC;
                acc_q   <= '0;
                db_q    <= '0;
                bv_q    <= 1'b0;
                pc_q    <= '0;
                last_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end else begin
              avail_q <= navail;
              state_q <= S_EMIT_RD;
            end
          end
          S_EMIT_RD: state_q <= S_EMIT_WAIT;
          S_EMIT_WAIT: begin
            if (out_free) begin
              ov_q   <= 1'b1;
              st_q   <= ST_OK;
              acc_q  <= '0;
              db_q   <= rd_byte[base[LB-1:0]];
              bv_q   <= 1'b1;
              pc_q   <= e_last ? 7'(avail_q) : 7'd0;
              last_q <= e_last;
              e_q    <= e_next;
              if (e_last) begin
                pos_q   <= pos_q + AW'(avail_q);
                state_q <= S_IDLE;
              end else begin
                state_q <= S_EMIT_RD;
              end
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end

      if (cfg_we_i && (cfg_idx_i == CFG_CAPACITY)) capreg_q <= cfg_data_i[CAP_REG_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
module tb;
  import tsrb_pkg::*;

  typedef struct {
    status_e    st;
    logic [3:0] acc;
    logic [7:0] db;
    logic       bv;
    logic [6:0] pc;
    logic       last;
  } seg_result_t;

  typedef struct {
    logic        is_cfg;
    cfg_idx_e    idx;
    logic [31:0] data;
    op_e         op;
    logic [31:0] seq;
    logic [3:0]  len;
    logic [63:0] bytes;
    logic [6:0]  lim;
    logic        typed;
    status_e     tst;
    logic [3:0]  tacc;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  tsrb_in_if  in_ch ();
  tsrb_out_if out_ch ();

  tcp_stream_reassembly_buffer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the buffer
  logic [7:0]  shadow_bytes [CAPACITY_DEF];
  logic        shadow_present [CAPACITY_DEF];
  int unsigned shadow_rdpos;
  logic [31:0] shadow_init_seq;
  logic [12:0] shadow_cap;
  seg_result_t pending_q [$];

  // typed expectation travels with the request
  logic    cur_typed = 1'b0;
  status_e cur_tst = ST_OK;
  logic [3:0] cur_tacc = '0;

  int errs = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cyc = 0;
  int hold_until = 0;
  logic [7:0] stream_bytes [CAPACITY_DEF];
  stim_row_t dir_q [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.seq = '0;
    in_ch.segment_length = '0;
    in_ch.segment_bytes = '0;
    in_ch.read_limit = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc < hold_until) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int unsigned eff_cap();
    return (shadow_cap > CAPACITY_DEF) ? CAPACITY_DEF : int'(shadow_cap);
  endfunction

  task automatic predict_request(op_e op, logic [31:0] seq, logic [3:0] len_in,
                                 logic [63:0] bytes, logic [6:0] lim_in);
    int unsigned cap, len, lim, avail, fresh;
    logic [31:0] off;
    seg_result_t r;
    cap = eff_cap();
    r = '{ST_OK, 4'd0, 8'd0, 1'b0, 7'd0, 1'b1};
    if (op == OP_PUSH) begin
      len = (len_in > SEG_BYTES_DEF) ? SEG_BYTES_DEF : len_in;
      off = seq - shadow_init_seq;
      fresh = 0;
      if (len == 0) begin
        pending_q.push_back(r);
      end else if (off > cap || len > cap - off) begin
        r.st = ST_CAPACITY;
        pending_q.push_back(r);
      end else begin
        for (int i = 0; i < len; i++) begin
          if (shadow_present[off + i]) begin
            if (shadow_bytes[off + i] != bytes[8*i +: 8]) r.st = ST_CONFLICT;
          end else begin
            fresh++;
          end
        end
        if (r.st == ST_OK) begin
          for (int i = 0; i < len; i++) begin
            shadow_bytes[off + i] = bytes[8*i +: 8];
            shadow_present[off + i] = 1'b1;
          end
          r.acc = fresh[3:0];
        end
        pending_q.push_back(r);
      end
    end else begin
      lim = (lim_in > READ_MAX_DEF) ? READ_MAX_DEF : lim_in;
      avail = 0;
      while (avail <= lim && shadow_rdpos < cap && avail < cap - shadow_rdpos &&
             shadow_present[shadow_rdpos + avail])
        avail++;
      if (avail > lim) begin
        r.st = ST_TRUNC;
        pending_q.push_back(r);
      end else if (avail == 0) begin
        pending_q.push_back(r);
      end else begin
        for (int i = 0; i < avail; i++) begin
          r.db = shadow_bytes[shadow_rdpos + i];
          r.bv = 1'b1;
          r.last = (i + 1 == avail);
          r.pc = r.last ? avail[6:0] : 7'd0;
          pending_q.push_back(r);
        end
        shadow_rdpos += avail;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_request(op_e'(in_ch.operation), in_ch.seq, in_ch.segment_length,
                      in_ch.segment_bytes, in_ch.read_limit);
      if (cur_typed) begin
        pending_q[pending_q.size()-1].st = cur_tst;
        pending_q[pending_q.size()-1].acc = cur_tacc;
      end
    end
  end

  always @(posedge clk_i) begin
    seg_result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, out_ch.status);
        errs++;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.status != e.st || out_ch.accepted_count != e.acc ||
            out_ch.data_byte != e.db || out_ch.byte_valid != e.bv ||
            out_ch.produced_count != e.pc || out_ch.last != e.last) begin
          $display("%0t: mismatch exp st=%0d acc=%0d db=%h bv=%0d pc=%0d last=%0d",
                   $time, e.st, e.acc, e.db, e.bv, e.pc, e.last);
          $display("%0t:          act st=%0d acc=%0d db=%h bv=%0d pc=%0d last=%0d",
                   $time, out_ch.status, out_ch.accepted_count, out_ch.data_byte,
                   out_ch.byte_valid, out_ch.produced_count, out_ch.last);
          errs++;
        end
      end
    end
  end

  task automatic send_request(stim_row_t s);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= s.op;
    in_ch.seq <= s.seq;
    in_ch.segment_length <= s.len;
    in_ch.segment_bytes <= s.bytes;
    in_ch.read_limit <= s.lim;
    cur_typed <= s.typed;
    cur_tst <= s.tst;
    cur_tacc <= s.tacc;
    do @(posedge clk_i); while (!in_ch.ready);
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BASE_SEQ) begin
      shadow_init_seq = data;
      shadow_rdpos = 0;
      foreach (shadow_present[i]) shadow_present[i] = 1'b0;
    end else begin
      shadow_cap = data[12:0];
    end
  endtask

  function automatic stim_row_t push_row(logic [31:0] seq, logic [3:0] len,
                                         logic [63:0] bytes, logic typed = 1'b0,
                                         status_e tst = ST_OK, logic [3:0] tacc = 0);
    return '{1'b0, CFG_BASE_SEQ, 32'd0, OP_PUSH, seq, len, bytes, 7'd0,
             typed, tst, tacc};
  endfunction

  function automatic stim_row_t read_row(logic [6:0] lim, logic typed = 1'b0,
                                         status_e tst = ST_OK);
    return '{1'b0, CFG_BASE_SEQ, 32'd0, OP_READ, 32'd0, 4'd0, 64'd0, lim,
             typed, tst, 4'd0};
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [31:0] data);
    return '{1'b1, idx, data, OP_PUSH, 32'd0, 4'd0, 64'd0, 7'd0, 1'b0, ST_OK, 4'd0};
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t s;
    int unsigned off, base;
    s = read_row(7'd0);
    if ($urandom_range(99) < 30) begin
      s.lim = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
      return s;
    end
    s.op = OP_PUSH;
    s.len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
    base = shadow_rdpos;
    if ($urandom_range(9) == 0) off = eff_cap() - $urandom_range(0, 8);
    else off = base + $urandom_range(0, 40);
    off = off % CAPACITY_DEF;
    for (int i = 0; i < 8; i++) s.bytes[8*i +: 8] = stream_bytes[(off + i) % CAPACITY_DEF];
    if ($urandom_range(99) < 12) s.bytes = {$urandom, $urandom};
    s.seq = shadow_init_seq + off;
    if ($urandom_range(99) < 5) s.seq = $urandom;
    return s;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    shadow_init_seq = '0;
    shadow_cap = 13'd4096;
    shadow_rdpos = 0;
    foreach (shadow_present[i]) shadow_present[i] = 1'b0;

    dir_q.push_back(read_row(7'd0, 1'b1, ST_OK));
    dir_q.push_back(push_row(32'd0, 4'd0, 64'hDEAD_BEEF_0000_1111, 1'b1, ST_OK, 4'd0));
    dir_q.push_back(push_row(32'd0, 4'd8, '1, 1'b1, ST_OK, 4'd8));
    dir_q.push_back(push_row(32'd0, 4'd15, '1, 1'b1, ST_OK, 4'd0));
    dir_q.push_back(push_row(32'd4, 4'd8, '0, 1'b1, ST_CONFLICT, 4'd0));
    dir_q.push_back(push_row(32'd4092, 4'd4, 64'h1234_5678, 1'b1, ST_OK, 4'd4));
    dir_q.push_back(push_row(32'd4093, 4'd4, 64'h0, 1'b1, ST_CAPACITY, 4'd0));
    dir_q.push_back(push_row(32'hFFFF_FFFF, 4'd1, 64'h0, 1'b1, ST_CAPACITY, 4'd0));
    dir_q.push_back(push_row(32'd8, 4'd8, '0, 1'b1, ST_OK, 4'd8));
    dir_q.push_back(read_row(7'd15, 1'b1, ST_TRUNC));
    dir_q.push_back(read_row(7'd127));
    dir_q.push_back(read_row(7'd64, 1'b1, ST_OK));
    dir_q.push_back(push_row(32'd16, 4'd8, 64'hA5C3_0F96_5AE1_7B2D));
    dir_q.push_back(read_row(7'd100));
    dir_q.push_back(cfg_row(CFG_CAPACITY, 32'd16));
    // read position now lies past the capacity in use
    dir_q.push_back(read_row(7'd64, 1'b1, ST_OK));
    dir_q.push_back(push_row(32'd16, 4'd1, 64'h55, 1'b1, ST_CAPACITY, 4'd0));
    dir_q.push_back(cfg_row(CFG_CAPACITY, 32'h1FFF));
    dir_q.push_back(push_row(32'd4088, 4'd4, 64'h8899_AABB, 1'b1, ST_OK, 4'd4));
    dir_q.push_back(cfg_row(CFG_CAPACITY, 32'd0));
    dir_q.push_back(push_row(32'd0, 4'd1, 64'h77, 1'b1, ST_CAPACITY, 4'd0));
    dir_q.push_back(cfg_row(CFG_BASE_SEQ, 32'hFFFF_FFFF));
    dir_q.push_back(cfg_row(CFG_CAPACITY, 32'd4096));
    dir_q.push_back(push_row(32'hFFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF, 1'b1, ST_OK,
                             4'd8));
    dir_q.push_back(push_row(32'd7, 4'd8, 64'hFEDC_BA98_7654_3210, 1'b1, ST_OK, 4'd8));
    dir_q.push_back(read_row(7'd64));

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) write_reg(dir_q[i].idx, dir_q[i].data);
      else send_request(dir_q[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 50; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 50; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      write_reg(CFG_BASE_SEQ, (ph == 0) ? 32'd0 : $urandom);
      case (ph)
        0: write_reg(CFG_CAPACITY, 32'd4096);
        1: write_reg(CFG_CAPACITY, 32'h1FFF);
        2: write_reg(CFG_CAPACITY, $urandom_range(40, 200));
        default: write_reg(CFG_CAPACITY, $urandom_range(1000, 4096));
      endcase
      foreach (stream_bytes[i]) stream_bytes[i] = 8'($urandom);
      if (ph == 2) hold_until = cyc + 400;
      for (int n = 0; n < 85; n++) begin
        send_request(random_row());
        if (ph == 1 && n == 40) drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errs == 0 && pending_q.size() == 0) begin
      $display("tcp_stream_reassembly_buffer_top test passed");
    end else begin
      $display("tcp_stream_reassembly_buffer_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tcp_stream_reassembly_buffer_top test failed");
    $finish;
  end

endmodule

/* tcp_stream_reassembly_buffer_top.f */
rtl/tsrb_pkg.sv
rtl/tsrb_if.sv
rtl/tsrb_lane.sv
rtl/tsrb_merge.sv
rtl/tcp_stream_reassembly_buffer_top.sv
sim/tb.sv
